@@ src/x86alu_pkg.sv @@
// ----------------------------------------------------------------------------
// x86alu_pkg
// Shared types and constants for the x86 integer ALU with flags: operation
// and source-kind codes, the decoded instruction and the execute result.
// ----------------------------------------------------------------------------
package x86alu_pkg;

   // register file geometry
   localparam int unsigned NumRegs   = 6;
   localparam int unsigned RegIdxW   = 3;
   localparam int unsigned DataW     = 32;
   localparam int unsigned CountW    = 5;
   localparam logic [DataW-1:0] MsbMask = 32'h8000_0000;

   // stream packing widths
   localparam int unsigned ReqDataW = 48;
   localparam int unsigned ReqUserW = 6;
   localparam int unsigned RspDataW = 40;
   localparam int unsigned RspUserW = 2;

   // operation codes
   typedef enum logic [2:0] {
      OP_MOV = 3'd0,
      OP_XOR = 3'd1,
      OP_CMP = 3'd2,
      OP_RCL = 3'd3,
      OP_SUB = 3'd4,
      OP_AND = 3'd5,
      OP_OR  = 3'd6,
      OP_SHR = 3'd7
   } op_type;

   // source kinds; code three is undefined and faults for operations that use a source
   typedef enum logic [1:0] {
      SRC_REG = 2'd0,
      SRC_MEM = 2'd1,
      SRC_IMM = 2'd2
   } src_kind_type;

   // one decoded instruction
   typedef struct packed {
      op_type                mode;
      logic                  dest_is_memory;
      logic [RegIdxW-1:0]    dest_reg;
      src_kind_type          src_kind;
      logic [RegIdxW-1:0]    src_reg;
      logic [DataW-1:0]      src_value;
      logic [CountW-1:0]     count;
   } instr_type;

   // execute result, including register write control
   typedef struct packed {
      logic [DataW-1:0]      result_value;
      logic                  mem_write;
      logic                  carry_flag;
      logic                  zero_flag;
      logic                  sign_flag;
      logic                  fault;
      logic                  reg_we;
   } exec_type;

   // architectural flags
   typedef struct packed {
      logic carry;
      logic zero;
      logic sign;
   } flags_type;

endpackage

@@ src/x86alu_exec.sv @@
// ----------------------------------------------------------------------------
// x86alu_exec
// Combinational execute logic: operand checks, the eight operations, the
// 33-bit rotate through carry and the logical right shift, and flag update.
// ----------------------------------------------------------------------------
module x86alu_exec (
   input  x86alu_pkg::instr_type           instr,
   input  logic [x86alu_pkg::DataW-1:0]    src_reg_data,
   input  logic [x86alu_pkg::DataW-1:0]    dst_reg_data,
   input  x86alu_pkg::flags_type           flags,
   output x86alu_pkg::exec_type            res
);
   import x86alu_pkg::*;

   logic                    uses_src;
   logic                    imm_ok;
   logic                    src_fault;
   logic [DataW-1:0]        src;
   logic [DataW-1:0]        d;
   logic                    lt;
   logic [2*DataW+1:0]      rot_wide;
   logic [DataW:0]          rot;
   logic [DataW:0]          shr_wide;

   // operand legality
   always_comb begin
      uses_src = (instr.mode != OP_RCL) && (instr.mode != OP_SHR);
      imm_ok   = (instr.mode == OP_MOV) || (instr.mode == OP_AND) ||
                 (instr.mode == OP_OR);
      case (instr.src_kind)
         SRC_REG: src_fault = uses_src && (instr.src_reg >= RegIdxW'(NumRegs));
         SRC_MEM: src_fault = 1'b0;
         SRC_IMM: src_fault = uses_src && !imm_ok;
         default: src_fault = uses_src;
      endcase
      src = (instr.src_kind == SRC_REG) ? src_reg_data : instr.src_value;
   end

   // rotate {carry, dest} left by count over 33 bits
   assign d        = dst_reg_data;
   assign rot_wide = {flags.carry, d, flags.carry, d} << instr.count;
   assign rot      = rot_wide[2*DataW+1:DataW+1];
   // shift right; bit 0 holds the last bit shifted out
   assign shr_wide = {d, 1'b0} >> instr.count;
   assign lt       = (d < src);

   // operation select and flags
   always_comb begin
      res = '{
         result_value: '0,
         mem_write:    1'b0,
         carry_flag:   flags.carry,
         zero_flag:    flags.zero,
         sign_flag:    flags.sign,
         fault:        1'b0,
         reg_we:       1'b0
      };
      if (src_fault) begin
         res.fault = 1'b1;
      end else if (instr.dest_is_memory) begin
         if (instr.mode != OP_MOV) begin
            res.fault = 1'b1;
         end else begin
            res.result_value = src;
            res.mem_write    = 1'b1;
         end
      end else if (instr.dest_reg >= RegIdxW'(NumRegs)) begin
         res.fault = 1'b1;
      end else begin
         res.reg_we = 1'b1;
         unique case (instr.mode)
            OP_MOV: res.result_value = src;
            OP_XOR: res.result_value = d ^ src;
            OP_SUB: res.result_value = d - src;
            OP_AND: res.result_value = d & src;
            OP_OR:  res.result_value = d | src;
            OP_CMP: begin
               res.result_value = d;
               res.reg_we       = 1'b0;
               res.carry_flag   = lt;
               res.zero_flag    = (d == src);
               if (lt) begin
                  res.sign_flag = 1'b1;
               end
            end
            OP_RCL: begin
               res.result_value = rot[DataW-1:0];
               res.carry_flag   = rot[DataW];
            end
            OP_SHR: begin
               res.result_value = shr_wide[DataW:1];
               if (instr.count != '0) begin
                  res.carry_flag = shr_wide[0];
               end
            end
            default: res.result_value = d;
         endcase
      end
   end

endmodule

@@ src/x86_integer_alu_with_flags.sv @@
// ----------------------------------------------------------------------------
// x86_integer_alu_with_flags
// 32-bit integer execute unit with a six-entry register file and carry,
// zero and sign flags, fed by and answering on streaming channels.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one instruction per transaction; rsp_* returns exactly one
//   result per instruction, in order. A mov to memory returns the value to
//   store with mem_write set; an illegal operand combination returns fault
//   with a zero value and changes no register or flag.
//   The input register is loaded when a request is accepted, and the result
//   register is loaded from it once the result register is empty or taken.
//   Throughput: one instruction per cycle while rsp_tready is not held low;
//   the register file read is registered and bypassed from the instruction
//   leaving the execute stage, so dependent instructions issue back to back.
//   Reset clears the flags and both valid bits; register contents are
//   undefined until written.
//   When rsp_tready is low the result register holds; one more instruction
//   waits in the input register, after which req_tready drops.
// ----------------------------------------------------------------------------
module x86_integer_alu_with_flags (
   input  logic                               clock,
   input  logic                               reset,
   // request: tdata = dest_reg[2:0], src_reg[5:3], src_value[37:6],
   //          count[42:38], zero pad[47:43]
   //          tuser = mode[2:0], dest_is_memory[3], src_kind[5:4]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [x86alu_pkg::ReqDataW-1:0]    req_tdata,
   input  logic [x86alu_pkg::ReqUserW-1:0]    req_tuser,
   // response: tdata = result_value[31:0], carry_flag[32], zero_flag[33],
   //           sign_flag[34], zero pad[39:35]
   //           tuser = mem_write[0], fault[1]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [x86alu_pkg::RspDataW-1:0]    rsp_tdata,
   output logic [x86alu_pkg::RspUserW-1:0]    rsp_tuser
);
   import x86alu_pkg::*;

   instr_type          req_instr;
   logic               req_accept;
   logic               exe_adv;
   logic               rsp_free;

   instr_type          instr_ff;
   logic               exe_valid_ff,   exe_valid_in;
   logic [DataW-1:0]   src_data_ff;
   logic [DataW-1:0]   dst_data_ff;
   flags_type          flags_ff,       flags_in;
   exec_type           res;
   exec_type           rsp_ff;
   logic               rsp_valid_ff,   rsp_valid_in;

   logic [DataW-1:0]   regs [NumRegs];
   logic               wr_en;
   logic [RegIdxW-1:0] wr_addr;
   logic [RegIdxW-1:0] src_rd_addr;
   logic [RegIdxW-1:0] dst_rd_addr;

   // unpack request transaction
   assign req_instr = '{
      mode:           op_type'(req_tuser[2:0]),
      dest_is_memory: req_tuser[3],
      dest_reg:       req_tdata[2:0],
      src_kind:       src_kind_type'(req_tuser[5:4]),
      src_reg:        req_tdata[5:3],
      src_value:      req_tdata[37:6],
      count:          req_tdata[42:38]
   };

   // handshake and stage advance
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign exe_adv    = exe_valid_ff && rsp_free;
   assign req_tready = !exe_valid_ff || exe_adv;
   assign req_accept = req_tvalid && req_tready;

   assign exe_valid_in = req_accept ? 1'b1 : (exe_adv ? 1'b0 : exe_valid_ff);
   assign rsp_valid_in = exe_adv ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign flags_in     = exe_adv ? flags_type'{carry: res.carry_flag, zero: res.zero_flag,
                                               sign: res.sign_flag} : flags_ff;

   // register write from the instruction leaving execute
   assign wr_en   = exe_adv && res.reg_we;
   assign wr_addr = instr_ff.dest_reg;

   // out-of-range indexes fault downstream; read entry zero instead
   assign src_rd_addr = (req_instr.src_reg < RegIdxW'(NumRegs)) ? req_instr.src_reg : '0;
   assign dst_rd_addr = (req_instr.dest_reg < RegIdxW'(NumRegs)) ? req_instr.dest_reg : '0;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         exe_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         exe_valid_ff <= exe_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         flags_ff     <= flags_in;
      end
   end

   // register file: write port and two registered read ports with bypass
   always_ff @(posedge clock) begin
      if (wr_en) begin
         regs[wr_addr] <= res.result_value;
      end
      if (req_accept) begin
         instr_ff    <= req_instr;
         src_data_ff <= (wr_en && wr_addr == src_rd_addr) ? res.result_value
                                                          : regs[src_rd_addr];
         dst_data_ff <= (wr_en && wr_addr == dst_rd_addr) ? res.result_value
                                                          : regs[dst_rd_addr];
      end
   end

   // execute
   x86alu_exec u_exec (
      .instr        (instr_ff),
      .src_reg_data (src_data_ff),
      .dst_reg_data (dst_data_ff),
      .flags        (flags_ff),
      .res          (res)
   );

   // result register
   always_ff @(posedge clock) begin
      if (exe_adv) begin
         rsp_ff <= res;
      end
   end

   // pack response transaction
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_ff.sign_flag, rsp_ff.zero_flag, rsp_ff.carry_flag,
                        rsp_ff.result_value};
   assign rsp_tuser  = {rsp_ff.fault, rsp_ff.mem_write};

endmodule
